/* sv/tpd_pkg.sv */
// Shared constants, types and codes for the threshold pulse discriminator.
package tpd_pkg;

   // Waveform length sets the internal index width; reported indices keep 10 bits.
   localparam int WaveLength = 1024;
   localparam int IdxW       = $clog2(WaveLength);
   localparam int MinLenW    = 10;
   localparam int SumW       = ((IdxW > MinLenW) ? IdxW : MinLenW) + 1;

   localparam int SampleW = 16;
   localparam int OutIdxW = 10;
   localparam int CountW  = 10;
   localparam int FirstW  = 11;

   localparam logic [CountW-1:0]  CountMax   = {CountW{1'b1}};
   localparam logic [FirstW-1:0]  FirstNone  = {FirstW{1'b1}};
   localparam logic [IdxW-1:0]    IdxLast    = IdxW'(WaveLength - 1);

   // Configuration port.
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam logic [CsrIdxW-1:0] CsrThreshold = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrMinLength = 2'd1;

   localparam logic [SampleW-1:0] ThresholdReset = 16'd26214;
   localparam logic [MinLenW-1:0] MinLengthReset = 10'd7;

   // Result kinds.
   localparam logic KindPulse   = 1'b0;
   localparam logic KindSummary = 1'b1;

   // Result queue.
   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = FifoPtrW + 1;

   typedef struct packed {
      logic                     kind;
      logic [OutIdxW-1:0]       start_index;
      logic [CountW-1:0]        pulse_count;
      logic signed [FirstW-1:0] first_start;
      logic                     done_res;
   } rsp_type;

endpackage

/* sv/tpd_req_if.sv */
// Request channel: one digitizer sample with its end-of-waveform flag.
interface tpd_req_if;
   import tpd_pkg::*;

   logic               valid;
   logic               ready;
   logic [SampleW-1:0] sample;
   logic               last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

/* sv/tpd_rsp_if.sv */
// Result channel: counted pulse starts and end-of-waveform summaries.
interface tpd_rsp_if;
   import tpd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [OutIdxW-1:0]       start_index;
   logic [CountW-1:0]        pulse_count;
   logic signed [FirstW-1:0] first_start;
   logic                     done_res;

   modport source (output valid, output kind, output start_index, output pulse_count,
                   output first_start, output done_res, input ready);
   modport sink   (input valid, input kind, input start_index, input pulse_count,
                   input first_start, input done_res, output ready);
endinterface

/* sv/threshold_pulse_discriminator.sv */
// Threshold pulse discriminator top level: input register, pulse logic, result queue.
// Flow: an accepted request waits in the input register until the queue has room, is
//   then evaluated, and its pulse result enters the queue ahead of any summary.
// Throughput: one request per cycle; the four-entry result queue drains one result per
//   cycle, and a request is evaluated only when two queue entries are free.
// Reset (synchronous, active high): empties the queue and input register, clears the
//   waveform state, and returns threshold to 26214 and min_length to 7.
module threshold_pulse_discriminator
   import tpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   tpd_req_if.sink             req_ch,
   tpd_rsp_if.source           rsp_ch,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // Configuration registers.
   logic [SampleW-1:0] threshold_ff, threshold_in;
   logic [MinLenW-1:0] min_length_ff, min_length_in;

   // Input register.
   logic               in_valid_ff, in_valid_in;
   logic [SampleW-1:0] in_sample_ff, in_sample_in;
   logic               in_last_ff, in_last_in;

   // Waveform state.
   logic               pulse_active_ff, pulse_active_in;
   logic [IdxW-1:0]    pulse_begin_ff, pulse_begin_in;
   logic [IdxW-1:0]    sample_index_ff, sample_index_in;
   logic [CountW-1:0]  counted_ff, counted_in;
   logic [FirstW-1:0]  earliest_ff, earliest_in;

   // Result queue.
   rsp_type               fifo_ff [FifoDepth];
   rsp_type               fifo_in [FifoDepth];
   logic [FifoPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0]   fifo_count_ff, fifo_count_in;

   logic          process;
   logic          pop;
   logic          below;
   logic          above;
   logic          close;
   logic          count_pulse;
   logic [SumW-1:0] begin_plus_len;
   logic [CountW-1:0] counted_upd;
   logic [FirstW-1:0] earliest_upd;
   rsp_type       pulse_res;
   rsp_type       summary_res;
   logic          push_pulse;
   logic          push_summary;

   // Evaluate the held request only when the queue can take both possible results.
   assign process = in_valid_ff && (fifo_count_ff <= FifoCntW'(FifoDepth - 2));
   assign req_ch.ready = !in_valid_ff || process;
   assign pop = rsp_ch.valid && rsp_ch.ready;

   // ---- Configuration writes; unknown indices drop silently ----
   always_comb begin
      threshold_in  = threshold_ff;
      min_length_in = min_length_ff;
      if (csr_we) begin
         if (csr_index == CsrThreshold) begin
            threshold_in = csr_wdata[SampleW-1:0];
         end else if (csr_index == CsrMinLength) begin
            min_length_in = csr_wdata[MinLenW-1:0];
         end
      end
   end

   // ---- Input register: load on accept, drop once evaluated ----
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      in_last_in   = in_last_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in  = 1'b1;
         in_sample_in = req_ch.sample;
         in_last_in   = req_ch.last;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   // ---- Pulse logic ----
   // A sample equal to the threshold neither opens nor closes a pulse.
   assign below = in_sample_ff < threshold_ff;
   assign above = in_sample_ff > threshold_ff;
   assign close = above && pulse_active_ff;

   // Count the pulse when it lasted more than min_length samples.
   assign begin_plus_len = SumW'(pulse_begin_ff) + SumW'(min_length_ff);
   assign count_pulse    = close && (begin_plus_len < SumW'(sample_index_ff));

   // Saturate the count; latch the first counted start.
   assign counted_upd  = (count_pulse && counted_ff != CountMax) ?
                         counted_ff + CountW'(1) : counted_ff;
   assign earliest_upd = (count_pulse && earliest_ff == FirstNone) ?
                         {1'b0, OutIdxW'(pulse_begin_ff)} : earliest_ff;

   always_comb begin
      pulse_res.kind        = KindPulse;
      pulse_res.start_index = OutIdxW'(pulse_begin_ff);
      pulse_res.pulse_count = counted_upd;
      pulse_res.first_start = earliest_upd;
      pulse_res.done_res    = !in_last_ff;

      summary_res.kind        = KindSummary;
      summary_res.start_index = '0;
      summary_res.pulse_count = counted_upd;
      summary_res.first_start = earliest_upd;
      summary_res.done_res    = 1'b1;
   end

   always_comb begin
      pulse_active_in = pulse_active_ff;
      pulse_begin_in  = pulse_begin_ff;
      sample_index_in = sample_index_ff;
      counted_in      = counted_ff;
      earliest_in     = earliest_ff;
      if (process) begin
         if (below && !pulse_active_ff) begin
            pulse_active_in = 1'b1;
            pulse_begin_in  = sample_index_ff;
         end
         if (close) begin
            pulse_active_in = 1'b0;
         end
         counted_in  = counted_upd;
         earliest_in = earliest_upd;
         if (in_last_ff) begin
            // Clear for the next waveform; an open pulse is dropped.
            pulse_active_in = 1'b0;
            pulse_begin_in  = '0;
            sample_index_in = '0;
            counted_in      = '0;
            earliest_in     = FirstNone;
         end else if (sample_index_ff != IdxLast) begin
            // Hold the index at the end of an overlong waveform.
            sample_index_in = sample_index_ff + IdxW'(1);
         end
      end
   end

   // ---- Result queue: up to two pushes and one pop per cycle ----
   assign push_pulse   = process && count_pulse;
   assign push_summary = process && in_last_ff;

   always_comb begin
      fifo_in   = fifo_ff;
      wr_ptr_in = wr_ptr_ff;
      if (push_pulse) begin
         fifo_in[wr_ptr_in] = pulse_res;
         wr_ptr_in          = wr_ptr_in + FifoPtrW'(1);
      end
      if (push_summary) begin
         fifo_in[wr_ptr_in] = summary_res;
         wr_ptr_in          = wr_ptr_in + FifoPtrW'(1);
      end
      rd_ptr_in     = pop ? rd_ptr_ff + FifoPtrW'(1) : rd_ptr_ff;
      fifo_count_in = fifo_count_ff + FifoCntW'(push_pulse) + FifoCntW'(push_summary)
                      - FifoCntW'(pop);
   end

   assign rsp_ch.valid       = fifo_count_ff != '0;
   assign rsp_ch.kind        = fifo_ff[rd_ptr_ff].kind;
   assign rsp_ch.start_index = fifo_ff[rd_ptr_ff].start_index;
   assign rsp_ch.pulse_count = fifo_ff[rd_ptr_ff].pulse_count;
   assign rsp_ch.first_start = fifo_ff[rd_ptr_ff].first_start;
   assign rsp_ch.done_res    = fifo_ff[rd_ptr_ff].done_res;

   // ---- Registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= ThresholdReset;
         min_length_ff   <= MinLengthReset;
         in_valid_ff     <= 1'b0;
         pulse_active_ff <= 1'b0;
         pulse_begin_ff  <= '0;
         sample_index_ff <= '0;
         counted_ff      <= '0;
         earliest_ff     <= FirstNone;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         fifo_count_ff   <= '0;
      end else begin
         threshold_ff    <= threshold_in;
         min_length_ff   <= min_length_in;
         in_valid_ff     <= in_valid_in;
         pulse_active_ff <= pulse_active_in;
         pulse_begin_ff  <= pulse_begin_in;
         sample_index_ff <= sample_index_in;
         counted_ff      <= counted_in;
         earliest_ff     <= earliest_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         fifo_count_ff   <= fifo_count_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_sample_ff <= in_sample_in;
      in_last_ff   <= in_last_in;
      fifo_ff      <= fifo_in;
   end

   // ---- Assertions ----
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= FifoCntW'(FifoDepth))
      else $error("result queue overfilled");

   a_room_on_process: assert property (@(posedge clock) disable iff (reset)
      process |-> fifo_count_ff <= FifoCntW'(FifoDepth - 2))
      else $error("request evaluated without room for two results");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (process && in_last_ff) |=> (sample_index_ff == '0 && !pulse_active_ff
                                   && counted_ff == '0 && earliest_ff == FirstNone))
      else $error("waveform state not cleared after last sample");

   a_summary_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind == KindSummary) |-> rsp_ch.done_res)
      else $error("summary result without done flag");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      FifoPtrW'(wr_ptr_ff - rd_ptr_ff) == fifo_count_ff[FifoPtrW-1:0])
      else $error("queue pointers disagree with count");

endmodule
